// File: rtl/trd_pkg.sv
// trd_pkg: shared types and constants for the trailing repetition detector
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package trd_pkg;

   // default depth of the byte store
   localparam int MAX_LEN_DEFAULT = 256;

   // payload widths of the channels
   localparam int DATA_W  = 8;
   localparam int INDEX_W = 8;
   localparam int LEN_W   = 8;
   localparam int REPS_W  = 9;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_READ,
      ST_CMP,
      ST_DONE
   } trd_state_type;

endpackage

`default_nettype wire

// File: rtl/trd_chan_if.sv
// trd_chan_if: valid/ready channel interfaces for the byte items and the result items
// depends on trd_pkg for payload widths
`default_nettype none

interface trd_req_if import trd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface trd_rsp_if import trd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               found;
   logic [INDEX_W-1:0] start_index;
   logic [LEN_W-1:0]   pattern_length;
   logic [REPS_W-1:0]  repetitions;
   logic               overflow;

   modport source (output valid, output found, output start_index, output pattern_length,
                   output repetitions, output overflow, input ready);
   modport sink   (input valid, input found, input start_index, input pattern_length,
                   input repetitions, input overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/trailing_repetition_detector.sv
// trailing_repetition_detector: finds the shortest pattern repeated at the tail of a byte string
// depends on trd_pkg and the channel interfaces in trd_chan_if.sv
// usage
//   req_chan carries one byte per item, with last set on the final byte of a string.
//   after the final byte the block searches shifts k = 1, 2, ... and sends exactly one
//   item on rsp_chan: found, start_index, pattern_length, repetitions and overflow.
//   bytes past MAX_LEN are dropped; such a string reports not found with overflow set.
// loading and search
//   while loading, one byte is taken every cycle (req_chan.ready is high).
//   after the final byte the search runs on one shared byte comparator fed by the
//   two read ports of the byte store: each compared pair takes a registered memory
//   read (ST_READ) followed by a compare (ST_CMP). a shift k compares up to n-k
//   pairs; the last compare leaves the outcome in the result registers, so
//   rsp_chan.valid rises right after it. strings with overflow or fewer than two
//   bytes skip the search and offer the result in the cycle after the final byte.
// stalls and reset
//   req_chan.ready stays low from the final byte until the result item is taken;
//   the result is held in registers as long as rsp_chan.ready is low.
//   reset empties the string and returns to loading; no clearing pass is needed.
`default_nettype none

module trailing_repetition_detector import trd_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   trd_req_if.sink   req_chan,
   trd_rsp_if.source rsp_chan
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;  // store address width
   localparam int CW = $clog2(MAX_LEN + 1);                  // byte count width

   // control state
   trd_state_type state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;        // bytes held for the current string
   logic          ovf_ff, ovf_in;          // a byte was dropped

   // search state
   logic [CW-1:0] n_ff, n_in;              // string length under search
   logic [AW-1:0] k_ff, k_in;              // shift being tried
   logic [AW-1:0] ptr_a_ff, ptr_a_in;      // lower position i
   logic [AW-1:0] ptr_b_ff, ptr_b_in;      // upper position i+k
   logic [AW-1:0] ph_ff, ph_in;            // matches within the current period
   logic [CW-1:0] reps_ff, reps_in;        // full periods matched so far

   // result registers
   logic               res_found_ff, res_found_in;
   logic [INDEX_W-1:0] res_start_ff, res_start_in;
   logic [LEN_W-1:0]   res_len_ff, res_len_in;
   logic [REPS_W-1:0]  res_reps_ff, res_reps_in;
   logic               res_ovf_ff, res_ovf_in;

   // byte store and its registered read ports
   logic [DATA_W-1:0] store_mem [MAX_LEN];
   logic [DATA_W-1:0] rd_a_ff, rd_b_ff;

   logic          req_fire, rsp_fire;
   logic          has_room;
   logic [CW-1:0] fill_next;
   logic          ovf_next;
   logic          load_skip;      // final byte needs no search
   logic          pair_eq;
   logic          cmp_more;       // keep walking down for this shift
   logic          cmp_hit;        // this shift qualifies
   logic          k_last;         // no further shift to try
   logic [AW-1:0] ph_next;
   logic [CW-1:0] reps_next;

   assign req_fire = req_chan.valid & req_chan.ready;
   assign rsp_fire = rsp_chan.valid & rsp_chan.ready;

   // load bookkeeping
   assign has_room  = (fill_ff < CW'(MAX_LEN));
   assign fill_next = has_room ? fill_ff + CW'(1) : fill_ff;
   assign ovf_next  = ovf_ff | ~has_room;
   assign load_skip = ovf_next | (fill_next < CW'(2));

   // shared compare unit and period counting
   assign pair_eq = (rd_a_ff == rd_b_ff);
   always_comb begin
      ph_next   = ph_ff;
      reps_next = reps_ff;
      if (pair_eq) begin
         if (ph_ff == k_ff - AW'(1)) begin
            ph_next   = '0;
            reps_next = reps_ff + CW'(1);
         end else begin
            ph_next = ph_ff + AW'(1);
         end
      end
   end
   assign cmp_more = pair_eq & (ptr_a_ff != '0);
   assign cmp_hit  = (reps_next != '0);
   assign k_last   = ((CW'(k_ff) + CW'(1)) == n_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_chan.last) begin
               state_in = load_skip ? ST_DONE : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (cmp_more) begin
               state_in = ST_READ;
            end else if (cmp_hit || k_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (rsp_fire) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      req_chan.ready = (state_ff == ST_LOAD);
      rsp_chan.valid = (state_ff == ST_DONE);
   end

   assign rsp_chan.found          = res_found_ff;
   assign rsp_chan.start_index    = res_start_ff;
   assign rsp_chan.pattern_length = res_len_ff;
   assign rsp_chan.repetitions    = res_reps_ff;
   assign rsp_chan.overflow       = res_ovf_ff;

   // datapath
   always_comb begin
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      ptr_a_in     = ptr_a_ff;
      ptr_b_in     = ptr_b_ff;
      ph_in        = ph_ff;
      reps_in      = reps_ff;
      res_found_in = res_found_ff;
      res_start_in = res_start_ff;
      res_len_in   = res_len_ff;
      res_reps_in  = res_reps_ff;
      res_ovf_in   = res_ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               fill_in = fill_next;
               ovf_in  = ovf_next;
               if (req_chan.last) begin
                  // string complete: freeze its length and start with shift 1
                  n_in         = fill_next;
                  fill_in      = '0;
                  ovf_in       = 1'b0;
                  k_in         = AW'(1);
                  ptr_a_in     = AW'(fill_next - CW'(2));
                  ptr_b_in     = AW'(fill_next - CW'(1));
                  ph_in        = '0;
                  reps_in      = '0;
                  res_found_in = 1'b0;
                  res_start_in = '0;
                  res_len_in   = '0;
                  res_reps_in  = '0;
                  res_ovf_in   = ovf_next;
               end
            end
         end
         ST_READ: begin
         end
         ST_CMP: begin
            ph_in   = ph_next;
            reps_in = reps_next;
            if (cmp_more) begin
               ptr_a_in = ptr_a_ff - AW'(1);
               ptr_b_in = ptr_b_ff - AW'(1);
            end else if (cmp_hit) begin
               res_found_in = 1'b1;
               // the run reached position 0 only if the last pair matched
               res_start_in = pair_eq ? '0 : INDEX_W'(ptr_a_ff + AW'(1));
               res_len_in   = LEN_W'(k_ff);
               res_reps_in  = REPS_W'(reps_next + CW'(1));
            end else if (!k_last) begin
               k_in     = k_ff + AW'(1);
               ptr_a_in = AW'(n_ff - CW'(k_ff) - CW'(2));
               ptr_b_in = AW'(n_ff - CW'(1));
               ph_in    = '0;
               reps_in  = '0;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      k_ff         <= k_in;
      ptr_a_ff     <= ptr_a_in;
      ptr_b_ff     <= ptr_b_in;
      ph_ff        <= ph_in;
      reps_ff      <= reps_in;
      res_found_ff <= res_found_in;
      res_start_ff <= res_start_in;
      res_len_ff   <= res_len_in;
      res_reps_ff  <= res_reps_in;
      res_ovf_ff   <= res_ovf_in;
   end

   // byte store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (req_fire && has_room) begin
         store_mem[fill_ff[AW-1:0]] <= req_chan.data_byte;
      end
      rd_a_ff <= store_mem[ptr_a_ff];
      rd_b_ff <= store_mem[ptr_b_ff];
   end

   // checks

   // loading and reporting never overlap
   assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("byte item taken while a result is pending");

   // every compare follows a read cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> ($past(state_ff) == ST_READ))
      else $error("compare without a preceding store read");

   // the fill count never exceeds the store depth
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_LEN))
      else $error("fill count beyond store depth");

   // a reported pattern never comes from a truncated string and never has zero length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.found) |-> (!rsp_chan.overflow && rsp_chan.pattern_length != '0))
      else $error("pattern reported for an overflowed string or with zero length");

endmodule

`default_nettype wire
